@@ rtl/ipatp_pkg.sv @@
// ----------------------------------------------------------------------------
// IP address text parser package
// Transfer types, character codes, syntax flags and status codes.
// ----------------------------------------------------------------------------
package ipatp_pkg;

  // One character of address text and the family it belongs to
  typedef struct packed {
    logic [7:0] text_char;
    logic [1:0] family;
  } in_item_t;

  // One parse result, produced at the terminator
  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] addr_high;
    logic [63:0] addr_low;
  } out_item_t;

  // Address families
  localparam logic [1:0] FAM_IPV4 = 2'd0;
  localparam logic [1:0] FAM_IPV6 = 2'd1;

  // Result status codes
  localparam logic [1:0] ST_MALFORMED   = 2'd0;
  localparam logic [1:0] ST_OK          = 2'd1;
  localparam logic [1:0] ST_UNSUPPORTED = 2'd2;

  // Syntax flags of the IPv6 scanner
  localparam logic [2:0] FLAG_COLON_OK  = 3'b001;
  localparam logic [2:0] FLAG_COLON_WAS = 3'b010;
  localparam logic [2:0] FLAG_DIGIT_OK  = 3'b100;

  // Characters
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;

  // Nibble budget of a full IPv6 address, and parse limits
  localparam logic [5:0] NIBBLES_FULL   = 6'd32;
  localparam logic [5:0] DOT_NL_MIN     = 6'd5;
  localparam logic [5:0] DOT_NL_MAX     = 6'd27;
  localparam logic [9:0] DEC_SATURATE   = 10'd1023;
  localparam logic [9:0] OCTET_MAX      = 10'd255;

endpackage

@@ rtl/ip_address_text_parser.sv @@
// ----------------------------------------------------------------------------
// IP address text parser
// Parses IPv4 dotted decimal and IPv6 text one character per transfer and
// returns status and the 128-bit address at the terminating zero byte.
// ----------------------------------------------------------------------------
// Throughput: one character per cycle; the parse state updates at each input
//   transfer through one level of compare, small add and group shift logic.
// Latency: the result is valid in the cycle after the terminator transfer and
//   holds in the output register until taken; while it waits untaken, every
//   input transfer stalls.
// Reset: rst clears parse state to "start of string" and empties the output.
module ip_address_text_parser (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 text_valid,
  output logic                 text_ready,
  input  ipatp_pkg::in_item_t  text_data,
  output logic                 result_valid,
  input  logic                 result_ready,
  output ipatp_pkg::out_item_t result_data
);

  // Parse state
  logic [1:0]   family_latched;
  logic         at_string_start;
  logic         failed;
  logic [2:0]   syntax_flags;
  logic [5:0]   nibbles_left;
  logic         compression_seen;
  logic [15:0]  group_value;
  logic [9:0]   group_decimal;
  logic         group_has_letter;
  logic [127:0] head_groups;
  logic [127:0] tail_groups;
  logic         dotted_mode;
  logic [7:0]   octet_values [4];
  logic [1:0]   octet_index;

  logic [1:0]   family_latched_next;
  logic         at_string_start_next;
  logic         failed_next;
  logic [2:0]   syntax_flags_next;
  logic [5:0]   nibbles_left_next;
  logic         compression_seen_next;
  logic [15:0]  group_value_next;
  logic [9:0]   group_decimal_next;
  logic         group_has_letter_next;
  logic [127:0] head_groups_next;
  logic [127:0] tail_groups_next;
  logic         dotted_mode_next;
  logic [7:0]   octet_values_next [4];
  logic [1:0]   octet_index_next;
  ipatp_pkg::out_item_t result_next;

  logic accept;
  logic is_end;

  // Accept a character whenever the output register is free or being drained
  assign text_ready = !result_valid || result_ready;
  assign accept     = text_valid && text_ready;
  assign is_end     = (text_data.text_char == ipatp_pkg::CH_NUL);

  // Next parse state and result for the presented character
  always_comb begin
    logic [7:0]   c;
    logic [1:0]   fam;
    logic         is_dec;
    logic         is_hex;
    logic [3:0]   d;
    logic [11:0]  oct_sum;
    logic [13:0]  dec_sum;
    logic [15:0]  gv_new;
    logic [5:0]   nl;
    logic [5:0]   nl_dec;
    logic [2:0]   fl;
    logic [127:0] tail_fin;
    logic [5:0]   nl_fin;
    logic         ok;

    c   = text_data.text_char;
    fam = at_string_start ? text_data.family : family_latched;
    nl  = nibbles_left;

    is_dec = (c >= ipatp_pkg::CH_0) && (c <= ipatp_pkg::CH_9);
    is_hex = is_dec
          || ((c >= ipatp_pkg::CH_UA) && (c <= ipatp_pkg::CH_UF))
          || ((c >= ipatp_pkg::CH_LA) && (c <= ipatp_pkg::CH_LF));
    d      = is_dec ? c[3:0] : (is_hex ? c[3:0] + 4'd9 : 4'd0);

    oct_sum = ({4'b0, octet_values[octet_index]} << 3)
            + ({4'b0, octet_values[octet_index]} << 1) + {8'b0, d};
    dec_sum = ({4'b0, group_decimal} << 3) + ({4'b0, group_decimal} << 1)
            + {10'b0, d};
    gv_new  = {group_value[11:0], d};
    nl_dec  = nl - 6'd1;
    fl      = syntax_flags & ~ipatp_pkg::FLAG_COLON_WAS;
    tail_fin = tail_groups;
    nl_fin   = nl;
    ok       = !failed;

    // Hold by default
    family_latched_next   = family_latched;
    at_string_start_next  = at_string_start;
    failed_next           = failed;
    syntax_flags_next     = syntax_flags;
    nibbles_left_next     = nibbles_left;
    compression_seen_next = compression_seen;
    group_value_next      = group_value;
    group_decimal_next    = group_decimal;
    group_has_letter_next = group_has_letter;
    head_groups_next      = head_groups;
    tail_groups_next      = tail_groups;
    dotted_mode_next      = dotted_mode;
    octet_values_next     = octet_values;
    octet_index_next      = octet_index;
    result_next           = '0;

    if (at_string_start) begin
      family_latched_next  = text_data.family;
      at_string_start_next = 1'b0;
    end

    if (!is_end) begin
      if (!failed && (fam == ipatp_pkg::FAM_IPV4
                      || (fam == ipatp_pkg::FAM_IPV6 && dotted_mode))) begin
        // Dotted decimal: accumulate octet, advance on dot
        if (is_dec) begin
          if (oct_sum > 12'd255) failed_next = 1'b1;
          else octet_values_next[octet_index] = oct_sum[7:0];
        end else if (c == ipatp_pkg::CH_DOT) begin
          if (octet_index == 2'd3) begin
            failed_next = 1'b1;
          end else begin
            octet_index_next = octet_index + 2'd1;
            octet_values_next[octet_index + 2'd1] = 8'd0;
          end
        end else begin
          failed_next = 1'b1;
        end
      end else if (!failed && fam == ipatp_pkg::FAM_IPV6) begin
        // IPv6 hex groups
        if (nl == 6'd0) begin
          failed_next = 1'b1;
        end else if (syntax_flags[0] && c == ipatp_pkg::CH_COLON) begin
          if (syntax_flags[1]) begin
            // Second colon: move the groups so far to the head
            if (compression_seen) begin
              failed_next = 1'b1;
            end else begin
              head_groups_next      = tail_groups << {nl[5:2], 4'b0000};
              tail_groups_next      = '0;
              nibbles_left_next     = nl - 6'd4;
              compression_seen_next = 1'b1;
              syntax_flags_next     = ipatp_pkg::FLAG_DIGIT_OK;
            end
          end else begin
            if (nl[1:0] != 2'd0) begin
              nibbles_left_next     = {nl[5:2], 2'b00};
              tail_groups_next      = {tail_groups[111:0], group_value};
              group_value_next      = '0;
              group_decimal_next    = '0;
              group_has_letter_next = 1'b0;
              syntax_flags_next     = syntax_flags | ipatp_pkg::FLAG_COLON_WAS;
            end else if (nl == ipatp_pkg::NIBBLES_FULL) begin
              syntax_flags_next = ipatp_pkg::FLAG_COLON_OK | ipatp_pkg::FLAG_COLON_WAS;
            end else begin
              syntax_flags_next = ipatp_pkg::FLAG_COLON_OK | ipatp_pkg::FLAG_DIGIT_OK
                                | ipatp_pkg::FLAG_COLON_WAS;
            end
          end
        end else if (syntax_flags[2] && is_hex) begin
          // Hex digit: shift into the group, close it when full
          nibbles_left_next = nl_dec;
          if (nl_dec[1:0] == 2'd0) begin
            syntax_flags_next     = ipatp_pkg::FLAG_COLON_OK;
            tail_groups_next      = {tail_groups[111:0], gv_new};
            group_value_next      = '0;
            group_decimal_next    = '0;
            group_has_letter_next = 1'b0;
          end else begin
            group_value_next = gv_new;
            if (!is_dec) group_has_letter_next = 1'b1;
            else group_decimal_next = (dec_sum > 14'd1023) ? ipatp_pkg::DEC_SATURATE
                                                           : dec_sum[9:0];
            if (fl == ipatp_pkg::FLAG_DIGIT_OK && nl_dec > 6'd4)
              syntax_flags_next = ipatp_pkg::FLAG_COLON_OK | ipatp_pkg::FLAG_DIGIT_OK;
            else
              syntax_flags_next = fl;
          end
        end else if (syntax_flags[2] && c == ipatp_pkg::CH_DOT
                     && nl >= ipatp_pkg::DOT_NL_MIN && nl <= ipatp_pkg::DOT_NL_MAX
                     && nl[1:0] != 2'd0) begin
          // Switch to the embedded dotted IPv4 part
          if (group_has_letter || group_decimal > ipatp_pkg::OCTET_MAX) begin
            failed_next = 1'b1;
          end else begin
            octet_values_next[0] = group_decimal[7:0];
            octet_values_next[1] = 8'd0;
            octet_values_next[2] = 8'd0;
            octet_values_next[3] = 8'd0;
            octet_index_next     = 2'd1;
            nibbles_left_next    = {nl[5:2] - 4'd1, 2'b00};
            syntax_flags_next    = syntax_flags & ~ipatp_pkg::FLAG_COLON_WAS;
            dotted_mode_next     = 1'b1;
          end
        end else begin
          failed_next = 1'b1;
        end
      end
    end else begin
      // Terminator: finish the address and build the result
      if (dotted_mode) begin
        tail_fin = {tail_groups[95:0], octet_values[0], octet_values[1],
                    octet_values[2], octet_values[3]};
        if (octet_index != 2'd3) ok = 1'b0;
      end else begin
        if (syntax_flags[1]) ok = 1'b0;
        if (nl[1:0] != 2'd0) begin
          tail_fin = {tail_groups[111:0], group_value};
          nl_fin   = {nl[5:2], 2'b00};
        end
      end
      if (!compression_seen && nl_fin != 6'd0) ok = 1'b0;

      if (fam == ipatp_pkg::FAM_IPV4) begin
        if (!failed && octet_index == 2'd3) begin
          result_next.status   = ipatp_pkg::ST_OK;
          result_next.addr_low = {32'd0, octet_values[0], octet_values[1],
                                  octet_values[2], octet_values[3]};
        end else begin
          result_next.status = ipatp_pkg::ST_MALFORMED;
        end
      end else if (fam == ipatp_pkg::FAM_IPV6) begin
        if (ok) begin
          result_next.status    = ipatp_pkg::ST_OK;
          result_next.addr_high = head_groups[127:64] | tail_fin[127:64];
          result_next.addr_low  = head_groups[63:0] | tail_fin[63:0];
        end else begin
          result_next.status = ipatp_pkg::ST_MALFORMED;
        end
      end else begin
        result_next.status = ipatp_pkg::ST_UNSUPPORTED;
      end

      // Return to the start-of-string state
      family_latched_next   = ipatp_pkg::FAM_IPV4;
      at_string_start_next  = 1'b1;
      failed_next           = 1'b0;
      syntax_flags_next     = ipatp_pkg::FLAG_COLON_OK | ipatp_pkg::FLAG_DIGIT_OK;
      nibbles_left_next     = ipatp_pkg::NIBBLES_FULL;
      compression_seen_next = 1'b0;
      group_value_next      = '0;
      group_decimal_next    = '0;
      group_has_letter_next = 1'b0;
      head_groups_next      = '0;
      tail_groups_next      = '0;
      dotted_mode_next      = 1'b0;
      octet_values_next     = '{default: 8'd0};
      octet_index_next      = 2'd0;
    end
  end

  // Advance parse state on each input transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      family_latched   <= ipatp_pkg::FAM_IPV4;
      at_string_start  <= 1'b1;
      failed           <= 1'b0;
      syntax_flags     <= ipatp_pkg::FLAG_COLON_OK | ipatp_pkg::FLAG_DIGIT_OK;
      nibbles_left     <= ipatp_pkg::NIBBLES_FULL;
      compression_seen <= 1'b0;
      group_value      <= '0;
      group_decimal    <= '0;
      group_has_letter <= 1'b0;
      head_groups      <= '0;
      tail_groups      <= '0;
      dotted_mode      <= 1'b0;
      octet_values     <= '{default: 8'd0};
      octet_index      <= 2'd0;
    end else if (accept) begin
      family_latched   <= family_latched_next;
      at_string_start  <= at_string_start_next;
      failed           <= failed_next;
      syntax_flags     <= syntax_flags_next;
      nibbles_left     <= nibbles_left_next;
      compression_seen <= compression_seen_next;
      group_value      <= group_value_next;
      group_decimal    <= group_decimal_next;
      group_has_letter <= group_has_letter_next;
      head_groups      <= head_groups_next;
      tail_groups      <= tail_groups_next;
      dotted_mode      <= dotted_mode_next;
      octet_values     <= octet_values_next;
      octet_index      <= octet_index_next;
    end
  end

  // Load the result register at the terminator, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept && is_end) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_end) result_data <= result_next;
  end

  // Checks
  a_end_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept && is_end |=> result_valid)
    else $error("terminator transfer did not produce a result");

  a_char_gives_none: assert property (@(posedge clk) disable iff (rst)
    accept && !is_end |=> !result_valid)
    else $error("result appeared without a terminator");

  a_fail_zero_addr: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_data.status != ipatp_pkg::ST_OK |->
      result_data.addr_high == 64'd0 && result_data.addr_low == 64'd0)
    else $error("failed result carries a nonzero address");

  a_nibble_bound: assert property (@(posedge clk) disable iff (rst)
    nibbles_left <= ipatp_pkg::NIBBLES_FULL)
    else $error("nibble budget out of range");

endmodule

@@ tb/tb_ip_address_text_parser.sv @@
// ----------------------------------------------------------------------------
// Testbench for the IP address text parser
// Streams IPv4 and IPv6 address text, one character per transfer, through the
// parser and checks every status and address against an in-bench parse model.
// Directed strings cover the edges; random strings are mostly well-formed
// with random content, plus broken text and noise, under changing idling.
// ----------------------------------------------------------------------------
module tb_ip_address_text_parser;

  localparam logic [1:0] FAM_OTHER    = 2'd2;
  localparam int         HOLD_CYCLES  = 300;
  localparam int         STALL_LIMIT  = 2000;
  localparam int         TAIL_CYCLES  = 8;
  localparam int         PHASE_CHARS  = 290;
  localparam int         MAX_REPORTS  = 10;

  typedef enum int {EDIT_SWAP, EDIT_DROP, EDIT_CUT, EDIT_EXTRA} text_edit_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 text_valid;
  logic                 text_ready;
  ipatp_pkg::in_item_t  text_data;
  logic                 result_valid;
  logic                 result_ready;
  ipatp_pkg::out_item_t result_data;

  // Idling and hold-off control shared with the receiver process
  int send_idle_pct;
  int recv_idle_pct;
  int hold_req_cnt;

  // Run statistics
  int strings_sent;
  int chars_sent;
  int chars_counted;
  int results_seen;
  int n_parsed;
  int n_malformed;
  int n_unsupported;
  int mismatch_cnt;
  int quiet_cycles;

  // Text of the string under construction
  logic [7:0] addr_text[$];

  // Addresses the parser should return, oldest first
  ipatp_pkg::out_item_t expected_addr_q[$];

  // Parse state of the in-bench model
  logic [1:0]   ps_family;
  bit           ps_fresh;
  bit           ps_bad;
  logic [2:0]   ps_flags;
  int           ps_nibs;
  bit           ps_zipped;
  logic [15:0]  ps_grp;
  int           ps_grp_dec;
  bit           ps_grp_hex;
  logic [127:0] ps_head;
  logic [127:0] ps_tail;
  bit           ps_dotted;
  int           ps_octet[4];
  logic [1:0]   ps_oct_idx;

  ip_address_text_parser i_dut (
    .clk          (clk),
    .rst          (rst),
    .text_valid   (text_valid),
    .text_ready   (text_ready),
    .text_data    (text_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_data  (result_data)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Parse model
  // --------------------------------------------------------------------------

  function automatic void parse_clear();
    ps_family  = ipatp_pkg::FAM_IPV4;
    ps_fresh   = 1'b1;
    ps_bad     = 1'b0;
    ps_flags   = ipatp_pkg::FLAG_COLON_OK | ipatp_pkg::FLAG_DIGIT_OK;
    ps_nibs    = int'(ipatp_pkg::NIBBLES_FULL);
    ps_zipped  = 1'b0;
    ps_grp     = '0;
    ps_grp_dec = 0;
    ps_grp_hex = 1'b0;
    ps_head    = '0;
    ps_tail    = '0;
    ps_dotted  = 1'b0;
    ps_octet   = '{default: 0};
    ps_oct_idx = '0;
  endfunction

  // Shift one 16-bit group into the low end of the tail
  function automatic void push_group(logic [15:0] v);
    ps_tail = {ps_tail[111:0], v};
  endfunction

  function automatic void close_group();
    ps_nibs    = ps_nibs - (ps_nibs % 4);
    push_group(ps_grp);
    ps_grp     = '0;
    ps_grp_dec = 0;
    ps_grp_hex = 1'b0;
  endfunction

  // Dotted decimal: IPv4 text, or the embedded IPv4 tail of IPv6
  function automatic void dotted_char(logic [7:0] c);
    int j;
    int b;
    j = int'(ps_oct_idx);
    if (c >= ipatp_pkg::CH_0 && c <= ipatp_pkg::CH_9) begin
      b = int'(c) - int'(ipatp_pkg::CH_0) + ps_octet[j] * 10;
      if (b > int'(ipatp_pkg::OCTET_MAX)) ps_bad = 1'b1;
      else ps_octet[j] = b;
    end else if (c == ipatp_pkg::CH_DOT) begin
      if (j == 3) begin
        ps_bad = 1'b1;
      end else begin
        ps_oct_idx      = 2'(j + 1);
        ps_octet[j + 1] = 0;
      end
    end else begin
      ps_bad = 1'b1;
    end
  endfunction

  // IPv6 hex groups, colons and compression
  function automatic void v6_char(logic [7:0] c);
    int nl;
    int d;
    bit is_hex;
    bit is_letter;
    nl = ps_nibs;
    if (nl == 0) begin
      ps_bad = 1'b1;
      return;
    end
    if ((ps_flags & ipatp_pkg::FLAG_COLON_OK) != 0 && c == ipatp_pkg::CH_COLON) begin
      if ((ps_flags & ipatp_pkg::FLAG_COLON_WAS) != 0) begin
        if (ps_zipped) begin
          ps_bad = 1'b1;
          return;
        end
        if (nl >= int'(ipatp_pkg::NIBBLES_FULL)) ps_head = '0;
        else ps_head = ps_tail << (4 * nl);
        ps_tail   = '0;
        ps_nibs   = nl - 4;
        ps_zipped = 1'b1;
        ps_flags  = ipatp_pkg::FLAG_DIGIT_OK;
      end else begin
        if (nl % 4 != 0) close_group();
        else if (nl == int'(ipatp_pkg::NIBBLES_FULL)) ps_flags = ipatp_pkg::FLAG_COLON_OK;
        else ps_flags = ipatp_pkg::FLAG_COLON_OK | ipatp_pkg::FLAG_DIGIT_OK;
        ps_flags = ps_flags | ipatp_pkg::FLAG_COLON_WAS;
      end
      return;
    end
    if ((ps_flags & ipatp_pkg::FLAG_DIGIT_OK) != 0) begin
      is_hex    = 1'b1;
      is_letter = 1'b0;
      d         = 0;
      if (c >= ipatp_pkg::CH_0 && c <= ipatp_pkg::CH_9) begin
        d = int'(c) - int'(ipatp_pkg::CH_0);
      end else if (c >= ipatp_pkg::CH_UA && c <= ipatp_pkg::CH_UF) begin
        d = int'(c) - int'(ipatp_pkg::CH_UA) + 10;
        is_letter = 1'b1;
      end else if (c >= ipatp_pkg::CH_LA && c <= ipatp_pkg::CH_LF) begin
        d = int'(c) - int'(ipatp_pkg::CH_LA) + 10;
        is_letter = 1'b1;
      end else begin
        is_hex = 1'b0;
      end
      if (is_hex) begin
        ps_flags = ps_flags & ~ipatp_pkg::FLAG_COLON_WAS;
        ps_grp   = {ps_grp[11:0], d[3:0]};
        if (is_letter) begin
          ps_grp_hex = 1'b1;
        end else begin
          ps_grp_dec = ps_grp_dec * 10 + d;
          if (ps_grp_dec > int'(ipatp_pkg::DEC_SATURATE))
            ps_grp_dec = int'(ipatp_pkg::DEC_SATURATE);
        end
        ps_nibs = nl - 1;
        if (ps_nibs % 4 == 0) begin
          ps_flags = ipatp_pkg::FLAG_COLON_OK;
          close_group();
        end else if (ps_flags == ipatp_pkg::FLAG_DIGIT_OK && ps_nibs > 4) begin
          ps_flags = ipatp_pkg::FLAG_COLON_OK | ipatp_pkg::FLAG_DIGIT_OK;
        end
        return;
      end
      // Switch to the embedded IPv4 tail
      if (c == ipatp_pkg::CH_DOT && nl >= int'(ipatp_pkg::DOT_NL_MIN)
          && nl <= int'(ipatp_pkg::DOT_NL_MAX) && nl % 4 != 0) begin
        if (ps_grp_hex || ps_grp_dec > int'(ipatp_pkg::OCTET_MAX)) begin
          ps_bad = 1'b1;
          return;
        end
        ps_octet   = '{ps_grp_dec, 0, 0, 0};
        ps_oct_idx = 2'd1;
        ps_nibs    = nl + (4 - nl % 4) - 8;
        ps_flags   = ps_flags & ~ipatp_pkg::FLAG_COLON_WAS;
        ps_dotted  = 1'b1;
        return;
      end
    end
    ps_bad = 1'b1;
  endfunction

  // Advance the model by one accepted character; queue a result at the end
  function automatic void addr_parse_step(ipatp_pkg::in_item_t it);
    ipatp_pkg::out_item_t r;
    bit ok;
    if (ps_fresh) begin
      ps_family = it.family;
      ps_fresh  = 1'b0;
    end
    if (it.text_char != ipatp_pkg::CH_NUL) begin
      if (!ps_bad) begin
        if (ps_family == ipatp_pkg::FAM_IPV4
            || (ps_family == ipatp_pkg::FAM_IPV6 && ps_dotted))
          dotted_char(it.text_char);
        else if (ps_family == ipatp_pkg::FAM_IPV6)
          v6_char(it.text_char);
      end
      return;
    end
    r = '0;
    r.status = ipatp_pkg::ST_MALFORMED;
    if (ps_family == ipatp_pkg::FAM_IPV4) begin
      if (!ps_bad && ps_oct_idx == 2'd3) begin
        r.status   = ipatp_pkg::ST_OK;
        r.addr_low = {32'd0, ps_octet[0][7:0], ps_octet[1][7:0],
                      ps_octet[2][7:0], ps_octet[3][7:0]};
      end
    end else if (ps_family == ipatp_pkg::FAM_IPV6) begin
      ok = !ps_bad;
      if (ok && ps_dotted) begin
        if (ps_oct_idx != 2'd3) begin
          ok = 1'b0;
        end else begin
          push_group({ps_octet[0][7:0], ps_octet[1][7:0]});
          push_group({ps_octet[2][7:0], ps_octet[3][7:0]});
        end
      end else if (ok) begin
        if ((ps_flags & ipatp_pkg::FLAG_COLON_WAS) != 0) ok = 1'b0;
        else if (ps_nibs % 4 != 0) close_group();
      end
      if (ok && !ps_zipped && ps_nibs != 0) ok = 1'b0;
      if (ok) begin
        r.status    = ipatp_pkg::ST_OK;
        r.addr_high = ps_head[127:64] | ps_tail[127:64];
        r.addr_low  = ps_head[63:0] | ps_tail[63:0];
      end
    end else begin
      r.status = ipatp_pkg::ST_UNSUPPORTED;
    end
    expected_addr_q.push_back(r);
    parse_clear();
  endfunction

  // --------------------------------------------------------------------------
  // Sender
  // --------------------------------------------------------------------------

  // Offer one character, idle at random first, and hold until the transfer
  task automatic send_char(logic [7:0] c, logic [1:0] fam);
    ipatp_pkg::in_item_t it;
    it.text_char = c;
    it.family    = fam;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      text_valid <= 1'b0;
      @(negedge clk);
    end
    text_valid <= 1'b1;
    text_data  <= it;
    do @(posedge clk); while (!text_ready);
    addr_parse_step(it);
    chars_sent++;
  endtask

  // Send the built text and its terminator; only the first family counts
  task automatic send_txt(logic [1:0] fam);
    int i;
    logic [1:0] f;
    for (i = 0; i < addr_text.size(); i++) begin
      if (i == 0) f = fam;
      else f = 2'($urandom_range(2));
      send_char(addr_text[i], f);
    end
    if (addr_text.size() == 0) f = fam;
    else f = 2'($urandom_range(2));
    send_char(ipatp_pkg::CH_NUL, f);
    strings_sent++;
    chars_counted += addr_text.size() + 1;
  endtask

  task automatic load_text(string s);
    int i;
    addr_text.delete();
    for (i = 0; i < s.len(); i++) addr_text.push_back(s[i]);
  endtask

  task automatic send_str(string s, logic [1:0] fam);
    load_text(s);
    send_txt(fam);
  endtask

  // Drop valid and hold until every queued result has come back
  task automatic wait_drained();
    @(negedge clk);
    text_valid <= 1'b0;
    while (expected_addr_q.size() != 0) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Text generators
  // --------------------------------------------------------------------------

  // Append a decimal number up to 999 with leading zeros
  task automatic push_dec(int v, int zeros);
    repeat (zeros) addr_text.push_back(ipatp_pkg::CH_0);
    if (v >= 100) addr_text.push_back(8'(int'(ipatp_pkg::CH_0) + v / 100));
    if (v >= 10) addr_text.push_back(8'(int'(ipatp_pkg::CH_0) + (v / 10) % 10));
    addr_text.push_back(8'(int'(ipatp_pkg::CH_0) + v % 10));
  endtask

  // Append one hex group of one to four digits, rarely five, mixed case
  task automatic push_hex_group();
    int n;
    int r;
    int d;
    n = ($urandom_range(99) < 3) ? 5 : $urandom_range(4, 1);
    r = $urandom_range(99);
    repeat (n) begin
      if (r < 10) d = 0;
      else if (r < 20) d = 15;
      else d = $urandom_range(15);
      if (d < 10) addr_text.push_back(8'(int'(ipatp_pkg::CH_0) + d));
      else if ($urandom_range(1)) addr_text.push_back(8'(int'(ipatp_pkg::CH_UA) + d - 10));
      else addr_text.push_back(8'(int'(ipatp_pkg::CH_LA) + d - 10));
    end
  endtask

  // Append dotted decimal; outside IPv6 allow odd octet counts and empties
  task automatic gen_v4(bit embedded);
    int n;
    int i;
    int r;
    int v;
    int z;
    n = 4;
    if (!embedded && $urandom_range(99) < 8) n = $urandom_range(6, 1);
    for (i = 0; i < n; i++) begin
      if (i > 0) addr_text.push_back(ipatp_pkg::CH_DOT);
      r = $urandom_range(99);
      if (r < 10) v = 0;
      else if (r < 20) v = 255;
      else if (r < 24) v = $urandom_range(999, 256);
      else v = $urandom_range(255);
      if (r >= 97 && !embedded) continue;
      z = ($urandom_range(99) < (embedded ? 3 : 20)) ? $urandom_range(3, 1) : 0;
      push_dec(v, z);
    end
  endtask

  // Append IPv6 text: full or compressed, with an optional IPv4 tail
  task automatic gen_v6();
    bit embed;
    int avail;
    int k;
    int h;
    int i;
    embed = $urandom_range(99) < 25;
    avail = embed ? 6 : 8;
    if ($urandom_range(99) < 60) begin
      k = ($urandom_range(99) < 5) ? avail : $urandom_range(avail - 1);
      h = $urandom_range(k);
      for (i = 0; i < h; i++) begin
        if (i > 0) addr_text.push_back(ipatp_pkg::CH_COLON);
        push_hex_group();
      end
      addr_text.push_back(ipatp_pkg::CH_COLON);
      addr_text.push_back(ipatp_pkg::CH_COLON);
      for (i = 0; i < k - h; i++) begin
        if (i > 0) addr_text.push_back(ipatp_pkg::CH_COLON);
        push_hex_group();
      end
      if (embed) begin
        if (k - h > 0) addr_text.push_back(ipatp_pkg::CH_COLON);
        gen_v4(1'b1);
      end
    end else begin
      k = ($urandom_range(99) < 5) ? avail + 1 : avail;
      for (i = 0; i < k; i++) begin
        if (i > 0) addr_text.push_back(ipatp_pkg::CH_COLON);
        push_hex_group();
      end
      if (embed) begin
        addr_text.push_back(ipatp_pkg::CH_COLON);
        gen_v4(1'b1);
      end
    end
  endtask

  // Append a few characters, mostly near the digit, letter and separator edges
  task automatic gen_noise();
    string pool;
    int n;
    pool = ":.0123456789abcdefABCDEF/;@G`g";
    n = $urandom_range(10);
    repeat (n) begin
      if ($urandom_range(99) < 30) addr_text.push_back(8'($urandom_range(255, 1)));
      else addr_text.push_back(pool[$urandom_range(pool.len() - 1)]);
    end
  endtask

  // Build one random string: mostly well-formed, some broken, some noise
  task automatic build_random_text(output logic [1:0] fam);
    int roll;
    int p;
    text_edit_t edit;
    string extra;
    extra = "::.0fG";
    addr_text.delete();
    roll = $urandom_range(99);
    if (roll < 35) begin
      gen_v4(1'b0);
      fam = ipatp_pkg::FAM_IPV4;
    end else if (roll < 75) begin
      gen_v6();
      fam = ipatp_pkg::FAM_IPV6;
    end else if (roll < 85) begin
      if ($urandom_range(1)) begin
        gen_v4(1'b0);
        fam = ipatp_pkg::FAM_IPV4;
      end else begin
        gen_v6();
        fam = ipatp_pkg::FAM_IPV6;
      end
      // Break the string with one edit
      if (addr_text.size() > 0) begin
        p    = $urandom_range(addr_text.size() - 1);
        edit = text_edit_t'($urandom_range(3));
        case (edit)
          EDIT_SWAP: addr_text[p] = 8'($urandom_range(255, 1));
          EDIT_DROP: addr_text.delete(p);
          EDIT_CUT: begin
            while (addr_text.size() > p) addr_text.delete(addr_text.size() - 1);
          end
          default: addr_text.insert(p, extra[$urandom_range(extra.len() - 1)]);
        endcase
      end
    end else if (roll < 95) begin
      gen_noise();
      fam = 2'($urandom_range(1));
    end else begin
      if ($urandom_range(1)) gen_noise();
      else gen_v4(1'b0);
      fam = FAM_OTHER;
    end
    if (roll < 85 && $urandom_range(99) < 4) fam = 2'($urandom_range(2));
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Edges of both formats, empty strings and the unsupported family
  task automatic test_directed();
    send_str("0.0.0.0", ipatp_pkg::FAM_IPV4);
    send_str("255.255.255.255", ipatp_pkg::FAM_IPV4);
    send_str("000000010.0255.00.9", ipatp_pkg::FAM_IPV4);
    send_str("256.1.1.1", ipatp_pkg::FAM_IPV4);
    send_str("1.2.3", ipatp_pkg::FAM_IPV4);
    send_str("1.2.3.4.5", ipatp_pkg::FAM_IPV4);
    send_str("1..3.4", ipatp_pkg::FAM_IPV4);
    load_text("1.2.3.");
    addr_text.push_back(8'hFF);
    send_txt(ipatp_pkg::FAM_IPV4);
    send_str("", ipatp_pkg::FAM_IPV4);
    send_str("", ipatp_pkg::FAM_IPV6);
    send_str("", FAM_OTHER);
    send_str("1.2.3.4", FAM_OTHER);
    send_str("::", ipatp_pkg::FAM_IPV6);
    send_str("::1", ipatp_pkg::FAM_IPV6);
    send_str("1::", ipatp_pkg::FAM_IPV6);
    send_str("1:2:3:4:5:6:7:8", ipatp_pkg::FAM_IPV6);
    send_str("ffff:FFFF:abcd:ABCD:0:09:f:F0", ipatp_pkg::FAM_IPV6);
    send_str("1:2:3:4:5:6:7:8:9", ipatp_pkg::FAM_IPV6);
    send_str("12345::", ipatp_pkg::FAM_IPV6);
    send_str("1::2::3", ipatp_pkg::FAM_IPV6);
    send_str("::ffff:192.168.1.1", ipatp_pkg::FAM_IPV6);
    send_str("1:2:3:4:5:6:255.255.255.255", ipatp_pkg::FAM_IPV6);
    send_str("::256.1.1.1", ipatp_pkg::FAM_IPV6);
    send_str("::a1.2.3.4", ipatp_pkg::FAM_IPV6);
    send_str("1:", ipatp_pkg::FAM_IPV6);
    send_str(":1::2", ipatp_pkg::FAM_IPV6);
    send_str("::1.2.3", ipatp_pkg::FAM_IPV6);
    send_str("1:2:3:4:5:6:7:1.2.3.4", ipatp_pkg::FAM_IPV6);
    send_str("::1", ipatp_pkg::FAM_IPV4);
  endtask

  task automatic test_random(int target);
    int start;
    logic [1:0] fam;
    start = chars_counted;
    while (chars_counted - start < target) begin
      build_random_text(fam);
      send_txt(fam);
    end
  endtask

  // Stall the receiver while the sender keeps offering, then drain
  task automatic test_backpressure();
    int keep;
    logic [1:0] fam;
    keep = send_idle_pct;
    send_idle_pct = 0;
    hold_req_cnt++;
    repeat (16) begin
      build_random_text(fam);
      send_txt(fam);
    end
    send_idle_pct = keep;
    wait_drained();
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random stalls, plus a long hold-off on request
  // --------------------------------------------------------------------------
  initial begin : receiver
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    result_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        result_ready <= 1'b0;
        hold_left--;
      end else if (hold_seen != hold_req_cnt) begin
        hold_seen++;
        hold_left = HOLD_CYCLES - 1;
        result_ready <= 1'b0;
      end else begin
        result_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result check
  // --------------------------------------------------------------------------
  task automatic report_mismatch(string what, ipatp_pkg::out_item_t want,
                                 ipatp_pkg::out_item_t got);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_REPORTS)
      $display("%0t mismatch (%s): expected status %0d high %h low %h, %s %0d high %h low %h",
               $time, what, want.status, want.addr_high, want.addr_low,
               "got status", got.status, got.addr_high, got.addr_low);
  endtask

  always @(posedge clk) begin : check_results
    ipatp_pkg::out_item_t want;
    if (!rst && result_valid && result_ready) begin
      results_seen++;
      case (result_data.status)
        ipatp_pkg::ST_OK:        n_parsed++;
        ipatp_pkg::ST_MALFORMED: n_malformed++;
        default:                 n_unsupported++;
      endcase
      if (expected_addr_q.size() == 0) begin
        report_mismatch("no result expected", '0, result_data);
      end else begin
        want = expected_addr_q.pop_front();
        if (result_data.status !== want.status)
          report_mismatch("status", want, result_data);
        if (result_data.addr_high !== want.addr_high)
          report_mismatch("addr_high", want, result_data);
        if (result_data.addr_low !== want.addr_low)
          report_mismatch("addr_low", want, result_data);
      end
    end
  end

  // End the run when neither channel has moved for too long
  always @(posedge clk) begin
    if (rst || (text_valid && text_ready) || (result_valid && result_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb_ip_address_text_parser: no transfer for %0d cycles", quiet_cycles);
        $display("tb_ip_address_text_parser: done, errors");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst           = 1'b1;
    text_valid    = 1'b0;
    text_data     = '0;
    send_idle_pct = 7;
    recv_idle_pct = 73;
    hold_req_cnt  = 0;
    strings_sent  = 0;
    chars_sent    = 0;
    chars_counted = 0;
    results_seen  = 0;
    n_parsed      = 0;
    n_malformed   = 0;
    n_unsupported = 0;
    mismatch_cnt  = 0;
    parse_clear();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Sender mostly busy, receiver mostly stalled
    test_directed();
    test_random(PHASE_CHARS);
    test_backpressure();

    // Sender mostly idle, receiver mostly ready
    send_idle_pct = 73;
    recv_idle_pct = 7;
    test_random(PHASE_CHARS);
    wait_drained();

    // Full rate on both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(PHASE_CHARS);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    mismatch_cnt += expected_addr_q.size();

    $display("tb_ip_address_text_parser: %0d strings, %0d characters, %0d results",
             strings_sent, chars_sent, results_seen);
    $display("tb_ip_address_text_parser: %0d parsed, %0d malformed, %0d unsupported",
             n_parsed, n_malformed, n_unsupported);
    $display("tb_ip_address_text_parser: %0d mismatches", mismatch_cnt);
    if (mismatch_cnt == 0)
      $display("tb_ip_address_text_parser: done, clean");
    else
      $display("tb_ip_address_text_parser: done, errors");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/ipatp_pkg.sv
rtl/ip_address_text_parser.sv
tb/tb_ip_address_text_parser.sv
